// ===== rtl/psi_pkg.sv =====
// Shared types and constants for the particle state integrator.
// Depends on nothing; imported by every module under rtl.
package psi_pkg;

    localparam int unsigned QW = 32;
    localparam int unsigned UW = 31;

    typedef enum logic [2:0] {
        REG_TIME_STEP  = 3'd0,
        REG_FIELD_AX   = 3'd1,
        REG_FIELD_AY   = 3'd2,
        REG_SPEED_LX   = 3'd3,
        REG_SPEED_LY   = 3'd4,
        REG_BOUND_X    = 3'd5,
        REG_BOUND_Y    = 3'd6
    } t_reg_idx;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef struct packed {
        logic [UW-1:0] time_step;
        logic signed [QW-1:0] field_ax;
        logic signed [QW-1:0] field_ay;
        logic [UW-1:0] speed_lx;
        logic [UW-1:0] speed_ly;
        logic [UW-1:0] bound_x;
        logic [UW-1:0] bound_y;
    } t_cfg;

    // One stored particle.
    typedef struct packed {
        logic [UW-1:0]        mass;
        logic signed [QW-1:0] pos_x;
        logic signed [QW-1:0] pos_y;
        logic signed [QW-1:0] vel_x;
        logic signed [QW-1:0] vel_y;
        logic signed [QW-1:0] acc_x;
        logic signed [QW-1:0] acc_y;
    } t_entry;

    // Saturate a 66-bit signed value to 32 bits.
    function automatic logic signed [QW-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) sat32 = 32'sh7FFFFFFF;
        else if (v < lo) sat32 = 32'sh80000000;
        else sat32 = v[QW-1:0];
    endfunction

    // Symmetric clamp of a 34-bit signed sum.
    function automatic logic signed [QW-1:0] clampsym(input logic signed [33:0] v,
                                                      input logic [UW-1:0] lim);
        logic signed [33:0] l;
        logic signed [33:0] nl;
        l = $signed({3'b000, lim});
        nl = -l;
        if (v > l) clampsym = l[QW-1:0];
        else if (v < nl) clampsym = nl[QW-1:0];
        else clampsym = v[QW-1:0];
    endfunction

endpackage

// ===== rtl/psi_isqrt.sv =====
// Iterative 64-bit integer square root, one result bit per cycle.
// Depends on psi_pkg.
module psi_isqrt
    import psi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic        r_busy;
    logic        r_done;
    logic [64:0] trial;

    assign trial  = {1'b0, r_res} + {1'b0, r_bit};
    assign o_done = r_done;
    assign o_root = r_res[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= i_value;
                r_res  <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end else if (r_busy) begin
                // Advance one result bit.
                if ({1'b0, r_x} >= trial) begin
                    r_x   <= r_x - trial[63:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("root done held");
    a_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("root done while busy");
    a_bit_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $countones(r_bit) == 1) else $error("root bit lost");

endmodule

// ===== rtl/particle_state_integrator_core.sv =====
// Top level of the particle state integrator: entry memory, config, step sequencer.
// Depends on psi_pkg and psi_isqrt.
//
//  channel | ports                          | handshake
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data | write when i_cfg_we
//  command | i_start, i_action, i_slot, ...   | accept when i_start && !o_busy
//  result  | o_valid, o_out_slot, ...          | one-cycle strobe, no stall
//
// A load never raises o_busy. A step holds o_busy through the memory read, three
// multiply stages, the position sum, the wait on the 32-iteration square root,
// the momentum multiply and the write-back; the result strobe follows in the
// next cycle, when a new transaction may already be accepted.
// The square root loop is the longest part of a step. Reset is synchronous and clears
// control and config; the entry memory is undefined until loaded.
// The receiver cannot stall, so each result shows for exactly one cycle.
module particle_state_integrator_core
    import psi_pkg::*;
#(
    parameter int NUM_PARTICLES = 16
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_action,
    input  logic [3:0]           i_slot,
    input  logic [30:0]          i_load_mass,
    input  logic signed [31:0]   i_load_pos_x,
    input  logic signed [31:0]   i_load_pos_y,
    input  logic signed [31:0]   i_load_vel_x,
    input  logic signed [31:0]   i_load_vel_y,
    input  logic signed [31:0]   i_load_own_accel_x,
    input  logic signed [31:0]   i_load_own_accel_y,
    output logic                 o_valid,
    output logic [3:0]           o_out_slot,
    output logic signed [31:0]   o_new_pos_x,
    output logic signed [31:0]   o_new_pos_y,
    output logic signed [31:0]   o_new_vel_x,
    output logic signed [31:0]   o_new_vel_y,
    output logic [30:0]          o_momentum_out
);
    localparam int AW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_M1   = 8'b0000_0100,
        S_M2   = 8'b0000_1000,
        S_M3   = 8'b0001_0000,
        S_SQRT = 8'b0010_0000,
        S_MOM  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_cfg   r_cfg;
    t_state r_state;
    t_entry mem [NUM_PARTICLES];
    t_entry r_rd;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] slot_addr;
    logic [3:0]    r_slot;
    logic signed [31:0] r_fdx, r_fdy, r_iax, r_iay, r_vx, r_vy;
    logic signed [31:0] r_px, r_py, r_t1x, r_t1y, r_t2x, r_t2y;
    logic [63:0] r_sq;
    logic [30:0] r_mom;
    logic        r_valid;
    logic        sq_start, sq_done;
    logic [31:0] sq_root;
    logic        accept, in_range;
    logic signed [63:0] dt_s;

    // Floor of a*dt/65536, saturated.
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [63:0] d);
        logic signed [65:0] p;
        p = 66'(a) * 66'(d);
        mulq = sat32(p >>> 16);
    endfunction

    assign dt_s      = $signed({33'd0, r_cfg.time_step});
    assign slot_addr = AW'(i_slot);
    assign in_range  = ({28'd0, i_slot} < 32'(NUM_PARTICLES));
    assign accept    = i_start && (r_state == S_IDLE);
    assign o_busy    = (r_state != S_IDLE);
    assign sq_start  = (r_state == S_M3);

    psi_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_sq),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // Configuration writes; unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step <= 31'd65536;
            r_cfg.field_ax  <= '0;
            r_cfg.field_ay  <= '0;
            r_cfg.speed_lx  <= 31'h7FFFFFFF;
            r_cfg.speed_ly  <= 31'h7FFFFFFF;
            r_cfg.bound_x   <= 31'h7FFFFFFF;
            r_cfg.bound_y   <= 31'h7FFFFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TIME_STEP: r_cfg.time_step <= i_cfg_data[30:0];
                REG_FIELD_AX:  r_cfg.field_ax  <= i_cfg_data;
                REG_FIELD_AY:  r_cfg.field_ay  <= i_cfg_data;
                REG_SPEED_LX:  r_cfg.speed_lx  <= i_cfg_data[30:0];
                REG_SPEED_LY:  r_cfg.speed_ly  <= i_cfg_data[30:0];
                REG_BOUND_X:   r_cfg.bound_x   <= i_cfg_data[30:0];
                REG_BOUND_Y:   r_cfg.bound_y   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Entry memory: one write port, registered read.
    always_ff @(posedge i_clk) begin
        if (accept && in_range && i_action == ACT_LOAD) begin
            mem[slot_addr] <= '{mass: i_load_mass, pos_x: i_load_pos_x,
                pos_y: i_load_pos_y, vel_x: i_load_vel_x, vel_y: i_load_vel_y,
                acc_x: i_load_own_accel_x, acc_y: i_load_own_accel_y};
        end else if (r_state == S_OUT) begin
            // Write back the stepped state.
            mem[r_addr] <= '{mass: r_rd.mass, pos_x: r_px, pos_y: r_py,
                vel_x: r_vx, vel_y: r_vy, acc_x: r_rd.acc_x, acc_y: r_rd.acc_y};
        end
        if (accept) r_rd <= mem[slot_addr];
    end

    // Step sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (accept && in_range && i_action == ACT_STEP) begin
                    r_state <= S_READ;
                    r_addr  <= slot_addr;
                    r_slot  <= i_slot;
                end
                S_READ: begin
                    // Field and intrinsic terms.
                    r_fdx <= mulq(r_cfg.field_ax, dt_s);
                    r_fdy <= mulq(r_cfg.field_ay, dt_s);
                    r_iax <= mulq(r_rd.acc_x, dt_s);
                    r_iay <= mulq(r_rd.acc_y, dt_s);
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_vx <= clampsym(34'(r_rd.vel_x) + 34'(r_fdx) + 34'(r_iax),
                                     r_cfg.speed_lx);
                    r_vy <= clampsym(34'(r_rd.vel_y) + 34'(r_fdy) + 34'(r_iay),
                                     r_cfg.speed_ly);
                    r_t2x <= mulq(r_fdx, dt_s);
                    r_t2y <= mulq(r_fdy, dt_s);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_t1x <= mulq(r_vx, dt_s);
                    r_t1y <= mulq(r_vy, dt_s);
                    r_sq  <= 64'(64'(r_vx) * 64'(r_vx)) + 64'(64'(r_vy) * 64'(r_vy));
                    r_state <= S_M3;
                end
                S_M3: begin
                    // Half of the field term, floored.
                    r_px <= clampsym(34'(r_rd.pos_x) + 34'(r_t1x) + 34'(r_t2x >>> 1),
                                     r_cfg.bound_x);
                    r_py <= clampsym(34'(r_rd.pos_y) + 34'(r_t1y) + 34'(r_t2y >>> 1),
                                     r_cfg.bound_y);
                    r_state <= S_SQRT;
                end
                S_SQRT: if (sq_done) r_state <= S_MOM;
                S_MOM: begin
                    logic [62:0] m;
                    m = 63'(r_rd.mass) * 63'(sq_root);
                    r_mom <= (m[62:16] > 47'h7FFFFFFF) ? 31'h7FFFFFFF : m[46:16];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_out_slot     = r_slot;
    assign o_new_pos_x    = r_px;
    assign o_new_pos_y    = r_py;
    assign o_new_vel_x    = r_vx;
    assign o_new_vel_y    = r_vy;
    assign o_momentum_out = r_mom;

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_valid_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) == S_OUT) else $error("stray result");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> !$past(accept)) else $error("accept while busy");

endmodule
